@@ design/tag_nesting_validator_defines.svh @@
// Assertion macros shared by the tag nesting validator RTL.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef TAG_NESTING_VALIDATOR_DEFINES_SVH
`define TAG_NESTING_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled while in reset
`define TNV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tag nesting validator check failed");
// Next-cycle implication, sampled on clk and disabled while in reset
`define TNV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tag nesting validator check failed");
`else
`define TNV_ASSERT_NOW(label, ante, cons)
`define TNV_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ design/tnv_pkg.sv @@
// Package for the tag nesting validator: sizes, mode encodings, character codes
// and the CDATA header tables. Used by tnv_front, tnv_back and the top level.
package tnv_pkg;

	localparam int STACK_DEPTH  = 16;
	localparam int NAME_MAX_LEN = 9;
	localparam int LETTER_W     = 5;
	localparam int NAME_W       = LETTER_W * NAME_MAX_LEN;
	localparam int NAME_LEN_W   = $clog2(NAME_MAX_LEN + 1);
	localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam logic [2:0] HDR_LEN = 3'd7;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_CAP_A = 8'h41;
	localparam logic [7:0] CH_CAP_Z = 8'h5A;

	typedef enum logic [1:0] {
		FM_NORMAL,
		FM_HDR_UP,
		FM_HDR_LO,
		FM_BODY
	} front_mode_t;

	typedef enum logic [2:0] {
		PM_FIRST,
		PM_TEXT,
		PM_LT,
		PM_OPEN,
		PM_CLOSE,
		PM_FAIL
	} parse_mode_t;

	// Tokens handed from the CDATA filter to the tag parser for one request
	typedef struct packed {
		logic       lt_tok;      // a held '<' goes to the parser first
		logic       ch_tok;      // then this character
		logic [7:0] ch;
		logic       hdr_fail;    // CDATA header mismatch
		logic       lt_next;     // a '<' is still held after this request
		logic       normal_next; // filter back in normal mode after this request
	} front_tok_t;

	// Upper case CDATA header, one character per position
	function automatic logic [7:0] hdr_upper(input logic [2:0] k);
		logic [7:0] c;
		unique case (k)
			3'd0:    c = CH_LBRK;
			3'd1:    c = 8'h43;
			3'd2:    c = 8'h44;
			3'd3:    c = 8'h41;
			3'd4:    c = 8'h54;
			3'd5:    c = 8'h41;
			default: c = CH_LBRK;
		endcase
		return c;
	endfunction

	// Lower case CDATA header, one character per position
	function automatic logic [7:0] hdr_lower(input logic [2:0] k);
		logic [7:0] c;
		unique case (k)
			3'd0:    c = CH_LBRK;
			3'd1:    c = 8'h63;
			3'd2:    c = 8'h64;
			3'd3:    c = 8'h61;
			3'd4:    c = 8'h74;
			3'd5:    c = 8'h61;
			default: c = CH_LBRK;
		endcase
		return c;
	endfunction

	function automatic logic is_cap(input logic [7:0] c);
		return (c >= CH_CAP_A) && (c <= CH_CAP_Z);
	endfunction

endpackage

@@ design/tag_nesting_validator.sv @@
// Tag nesting validator: one byte per request, one verdict on the last byte.
// Throughput: one byte per cycle, set by the filter and parser update, unless a last byte
// must wait for an earlier verdict not yet taken. A last byte passes the input register, then the output register.
// The verdict sits in an output register while the next text's bytes are accepted.
// Reset: arst_n clears all control state at once; the tag stack needs no clearing.
`include "tag_nesting_validator_defines.svh"
module tag_nesting_validator import tnv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_byte,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_valid
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       out_valid_q;
	logic       is_valid_q;
	logic       adv;
	logic       failed;
	logic       ok;
	logic       step;
	logic       clear;
	front_tok_t tok;

	// Advance the input stage unless a verdict would overrun a waiting one
	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign step     = adv && !failed;
	assign clear    = adv && last_s1;

	// Hold the accepted request in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_byte;
			last_s1 <= last_char;
		end
	end

	tnv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.clear   (clear),
		.char_in (char_s1),
		.tok     (tok)
	);

	tnv_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.clear  (clear),
		.tok    (tok),
		.failed (failed),
		.ok     (ok)
	);

	// Load the verdict on the last byte; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (clear) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) is_valid_q <= ok;
	end

	assign out_valid = out_valid_q;
	assign is_valid  = is_valid_q;

	// A last byte always leaves a verdict behind
	`TNV_ASSERT_NEXT(a_last_gives_result, valid_s1 && adv && last_s1, out_valid_q)
	// A byte that is not last never raises a verdict of its own
	`TNV_ASSERT_NEXT(a_no_spurious_result, adv && !last_s1 && out_valid_q && out_ready, !out_valid_q)
	// An accepted request always lands in the input stage
	`TNV_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, valid_s1)

endmodule

@@ design/tnv_front.sv @@
// CDATA filter: holds '<' until the next byte, matches the CDATA header and
// collapses each CDATA section into one text token. Depends on tnv_pkg.
module tnv_front import tnv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       clear,
	input  logic [7:0] char_in,
	output front_tok_t tok
);

	front_mode_t mode_q, mode_n;
	logic        lt_q, lt_n;
	logic [2:0]  cnt_q, cnt_n;
	logic [1:0]  run_q, run_n;
	logic [2:0]  hdr_idx;
	logic        hit_up;
	logic        hit_lo;
	logic        bang;
	logic        body_end;

	// Clamp the header position and match this byte against both header spellings
	assign hdr_idx  = (cnt_q >= HDR_LEN) ? (HDR_LEN - 3'd1) : cnt_q;
	assign hit_up   = (mode_q == FM_HDR_UP) && (char_in == hdr_upper(hdr_idx));
	assign hit_lo   = (char_in == hdr_lower(hdr_idx)) &&
	                  (mode_q == FM_HDR_LO || hdr_idx == 3'd1);
	assign bang     = lt_q && (char_in == CH_BANG);
	assign body_end = (char_in == CH_GT) && (run_q == 2'd2);

	// Work out the next filter state for this byte
	always_comb begin
		mode_n = mode_q;
		lt_n   = lt_q;
		cnt_n  = cnt_q;
		run_n  = run_q;
		unique case (mode_q) inside
			FM_HDR_UP, FM_HDR_LO: begin
				if (hit_up || hit_lo) begin
					if (!hit_up) mode_n = FM_HDR_LO;
					cnt_n = hdr_idx + 3'd1;
					if (cnt_n == HDR_LEN) begin
						mode_n = FM_BODY;
						run_n  = 2'd0;
					end
				end else begin
					mode_n = FM_NORMAL;
				end
			end
			FM_BODY: begin
				if (char_in == CH_RBRK) begin
					if (run_q < 2'd2) run_n = run_q + 2'd1;
				end else if (body_end) begin
					mode_n = FM_NORMAL;
					run_n  = 2'd0;
				end else begin
					run_n = 2'd0;
				end
			end
			default: begin
				if (bang) begin
					mode_n = FM_HDR_UP;
					cnt_n  = 3'd0;
					lt_n   = 1'b0;
				end else begin
					lt_n = (char_in == CH_LT);
				end
			end
		endcase
	end

	// Hand the held '<' and this character to the parser
	always_comb begin
		tok.lt_tok   = 1'b0;
		tok.ch_tok   = 1'b0;
		tok.ch       = char_in;
		tok.hdr_fail = 1'b0;
		unique case (mode_q) inside
			FM_HDR_UP, FM_HDR_LO: begin
				tok.hdr_fail = !(hit_up || hit_lo);
			end
			FM_BODY: begin
				if (body_end) begin
					tok.ch_tok = 1'b1;
					tok.ch     = CH_HASH;
				end
			end
			default: begin
				tok.lt_tok = lt_q && !bang;
				tok.ch_tok = !bang && (char_in != CH_LT);
			end
		endcase
		tok.lt_next     = lt_n;
		tok.normal_next = (mode_n == FM_NORMAL);
	end

	// Advance the filter state; drop it back to reset after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= FM_NORMAL;
			lt_q   <= 1'b0;
			cnt_q  <= 3'd0;
			run_q  <= 2'd0;
		end else if (clear) begin
			mode_q <= FM_NORMAL;
			lt_q   <= 1'b0;
			cnt_q  <= 3'd0;
			run_q  <= 2'd0;
		end else if (step) begin
			mode_q <= mode_n;
			lt_q   <= lt_n;
			cnt_q  <= cnt_n;
			run_q  <= run_n;
		end
	end

endmodule

@@ design/tnv_back.sv @@
// Tag parser: checks names, nesting against the tag stack, the single root
// and trailing text, and forms the verdict. Depends on tnv_pkg.
module tnv_back import tnv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       clear,
	input  front_tok_t tok,
	output logic       failed,
	output logic       ok
);

	parse_mode_t             mode_q, mode_n;
	logic [NAME_W-1:0]       name_q, name_n;
	logic [NAME_LEN_W-1:0]   len_q, len_n;
	logic [CNT_W-1:0]        cnt_q, cnt_n;
	logic                    root_q, root_n;
	logic                    trail_q, trail_n;
	logic                    push;
	logic [NAME_W-1:0]       stack_mem [STACK_DEPTH];
	logic [CNT_W-1:0]        cnt_dec;
	logic [NAME_W-1:0]       top_name;

	assign cnt_dec  = cnt_q - CNT_W'(1);
	assign top_name = stack_mem[cnt_dec[PTR_W-1:0]];
	assign failed   = (mode_q == PM_FAIL);

	// Apply the held '<' first, then the character token
	always_comb begin
		logic letter_ok;
		mode_n  = mode_q;
		name_n  = name_q;
		len_n   = len_q;
		cnt_n   = cnt_q;
		root_n  = root_q;
		trail_n = trail_q;
		push    = 1'b0;

		if (tok.lt_tok) begin
			if (mode_n == PM_FIRST || mode_n == PM_TEXT) begin
				mode_n  = PM_LT;
				trail_n = 1'b0;
				name_n  = '0;
				len_n   = '0;
			end else begin
				mode_n = PM_FAIL;
			end
		end

		letter_ok = is_cap(tok.ch) && (len_n < NAME_LEN_W'(NAME_MAX_LEN));

		if (tok.ch_tok) begin
			unique case (mode_n) inside
				PM_FIRST, PM_TEXT: begin
					if (tok.ch == CH_LT) begin
						mode_n  = PM_LT;
						trail_n = 1'b0;
						name_n  = '0;
						len_n   = '0;
					end else if (mode_n == PM_FIRST) begin
						mode_n = PM_FAIL;
					end else begin
						trail_n = 1'b1;
					end
				end
				PM_LT: begin
					if (tok.ch == CH_SLASH) begin
						mode_n = PM_CLOSE;
					end else if (letter_ok) begin
						name_n = (name_n << LETTER_W) | NAME_W'(tok.ch[LETTER_W-1:0]);
						len_n  = len_n + NAME_LEN_W'(1);
						mode_n = PM_OPEN;
					end else begin
						mode_n = PM_FAIL;
					end
				end
				PM_OPEN, PM_CLOSE: begin
					if (tok.ch != CH_GT) begin
						if (letter_ok) begin
							name_n = (name_n << LETTER_W) | NAME_W'(tok.ch[LETTER_W-1:0]);
							len_n  = len_n + NAME_LEN_W'(1);
						end else begin
							mode_n = PM_FAIL;
						end
					end else if (mode_n == PM_OPEN) begin
						if ((cnt_q == '0 && root_q) || cnt_q >= CNT_W'(STACK_DEPTH)) begin
							mode_n = PM_FAIL;
						end else begin
							root_n = 1'b1;
							push   = 1'b1;
							cnt_n  = cnt_q + CNT_W'(1);
							mode_n = PM_TEXT;
						end
					end else begin
						if (len_n == '0 || cnt_q == '0 || top_name != name_n) begin
							mode_n = PM_FAIL;
						end else begin
							cnt_n  = cnt_dec;
							mode_n = PM_TEXT;
						end
					end
				end
				default: begin
					mode_n = PM_FAIL;
				end
			endcase
		end

		if (tok.hdr_fail) mode_n = PM_FAIL;
	end

	// Give the verdict as if this byte ends the text
	assign ok = (mode_n == PM_TEXT) && tok.normal_next && !tok.lt_next &&
	            (cnt_n == '0) && !trail_n;

	// Advance the parser state; drop it back to reset after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= PM_FIRST;
			name_q  <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			root_q  <= 1'b0;
			trail_q <= 1'b0;
		end else if (clear) begin
			mode_q  <= PM_FIRST;
			name_q  <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			root_q  <= 1'b0;
			trail_q <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_n;
			name_q  <= name_n;
			len_q   <= len_n;
			cnt_q   <= cnt_n;
			root_q  <= root_n;
			trail_q <= trail_n;
		end
	end

	// Write the open tag name on top of the stack
	always_ff @(posedge clk) begin
		if (step && push) stack_mem[cnt_q[PTR_W-1:0]] <= name_q;
	end

endmodule

@@ sim/tag_nesting_validator_tb.sv @@
`timescale 1ns / 100ps
// Testbench for tag_nesting_validator: streams code texts one byte per request and checks
// each verdict against a behavioral copy of the CDATA filter and the tag parser.
// Depends on tnv_pkg and the tag_nesting_validator RTL; reads and writes no files.
module tag_nesting_validator_tb;
	import tnv_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [55:0] CDATA_UPPER = "[CDATA[";
	localparam logic [55:0] CDATA_LOWER = "[cdata[";

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_req_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] char_byte = 8'h00;
	logic       last_char = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       is_valid;

	// Stimulus and scoreboard state
	char_req_t  outbox[$];
	char_req_t  next_req;
	logic       verdicts[$];
	logic [7:0] draft[$];
	int         tag_at[$];
	int         tag_len[$];
	int         items_queued   = 0;
	int         texts_queued   = 0;
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;
	logic       hold_go        = 1'b0;
	logic       hold_taken     = 1'b0;
	int         hold_left      = 0;
	logic       in_took        = 1'b0;
	int         err_count      = 0;
	int         quiet_cycles   = 0;
	logic       pred_done;
	logic       pred_ok;
	logic       exp_ok;

	// Behavioral state of the filter and parser
	front_mode_t           fm;
	logic                  lt_held;
	logic [2:0]            hdr_pos;
	logic [1:0]            rbrk_run;
	parse_mode_t           pm;
	logic [NAME_W-1:0]     name_acc;
	logic [NAME_LEN_W-1:0] name_len;
	logic [NAME_W-1:0]     tag_names[STACK_DEPTH];
	logic [CNT_W-1:0]      depth;
	logic                  root_seen;
	logic                  text_after;

	tag_nesting_validator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_byte(char_byte),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_valid (is_valid)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	// ---------------------------------------------------------------- text checker
	function automatic void checker_clear();
		fm         = FM_NORMAL;
		lt_held    = 1'b0;
		hdr_pos    = '0;
		rbrk_run   = '0;
		pm         = PM_FIRST;
		name_acc   = '0;
		name_len   = '0;
		depth      = '0;
		root_seen  = 1'b0;
		text_after = 1'b0;
	endfunction

	function automatic logic [7:0] cdata_char(input logic upper, input logic [2:0] k);
		logic [55:0] hdr;
		hdr = upper ? CDATA_UPPER : CDATA_LOWER;
		return hdr[8 * (6 - k) +: 8];
	endfunction

	// Append a capital to the tag name; anything else, or one too many, fails the text
	function automatic logic push_letter(input logic [7:0] c);
		if (c < CH_CAP_A || c > CH_CAP_Z || name_len >= NAME_MAX_LEN) begin
			pm = PM_FAIL;
			return 1'b0;
		end
		name_acc = (name_acc << LETTER_W) | NAME_W'(c - CH_CAP_A + 8'd1);
		name_len++;
		return 1'b1;
	endfunction

	function automatic void tag_parse(input logic [7:0] c);
		case (pm)
			PM_FIRST, PM_TEXT: begin
				if (c == CH_LT) begin
					pm         = PM_LT;
					text_after = 1'b0;
					name_acc   = '0;
					name_len   = '0;
				end else if (pm == PM_FIRST) begin
					pm = PM_FAIL;
				end else begin
					text_after = 1'b1;
				end
			end
			PM_LT: begin
				if (c == CH_SLASH) pm = PM_CLOSE;
				else if (push_letter(c)) pm = PM_OPEN;
			end
			PM_OPEN: begin
				if (c != CH_GT) begin
					void'(push_letter(c));
				end else if (depth == 0 && root_seen) begin
					pm = PM_FAIL;
				end else if (depth >= STACK_DEPTH) begin
					pm = PM_FAIL;
				end else begin
					root_seen        = 1'b1;
					tag_names[depth] = name_acc;
					depth++;
					pm = PM_TEXT;
				end
			end
			PM_CLOSE: begin
				if (c != CH_GT) begin
					void'(push_letter(c));
				end else if (name_len == 0 || depth == 0 || tag_names[depth - 1] != name_acc) begin
					pm = PM_FAIL;
				end else begin
					depth--;
					pm = PM_TEXT;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void filter_plain(input logic [7:0] c);
		if (c == CH_LT) lt_held = 1'b1;
		else tag_parse(c);
	endfunction

	// Match CDATA headers, skip bodies, hold '<' until the next byte shows a '!'
	function automatic void cdata_filter(input logic [7:0] c);
		logic [2:0] k;
		if (fm == FM_HDR_UP || fm == FM_HDR_LO) begin
			k = hdr_pos;
			if (k >= HDR_LEN) k = HDR_LEN - 3'd1;
			if (fm == FM_HDR_UP && c == cdata_char(1'b1, k)) begin
				// upper case, or the bracket both headers share
			end else if (c == cdata_char(1'b0, k) && (fm == FM_HDR_LO || k == 3'd1)) begin
				fm = FM_HDR_LO;
			end else begin
				pm = PM_FAIL;
				fm = FM_NORMAL;
				return;
			end
			hdr_pos = k + 3'd1;
			if (hdr_pos == HDR_LEN) begin
				fm       = FM_BODY;
				rbrk_run = '0;
			end
		end else if (fm == FM_BODY) begin
			if (c == CH_RBRK) begin
				if (rbrk_run < 2) rbrk_run++;
			end else if (c == CH_GT && rbrk_run == 2) begin
				fm       = FM_NORMAL;
				rbrk_run = '0;
				tag_parse(CH_HASH);
			end else begin
				rbrk_run = '0;
			end
		end else if (lt_held) begin
			lt_held = 1'b0;
			if (c == CH_BANG) begin
				fm      = FM_HDR_UP;
				hdr_pos = '0;
			end else begin
				tag_parse(CH_LT);
				filter_plain(c);
			end
		end else begin
			filter_plain(c);
		end
	endfunction

	// Take one byte; on the last byte give the verdict and start over
	function automatic void scan_char(input logic [7:0] c, input logic last,
			output logic done, output logic ok);
		done = 1'b0;
		ok   = 1'b0;
		if (pm != PM_FAIL) cdata_filter(c);
		if (last) begin
			if (pm != PM_FAIL && lt_held) begin
				lt_held = 1'b0;
				tag_parse(CH_LT);
			end
			ok   = pm == PM_TEXT && fm == FM_NORMAL && depth == 0 && !text_after;
			done = 1'b1;
			checker_clear();
		end
	endfunction

	// ---------------------------------------------------------------- text builders
	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++) draft.insert(draft.size(), s[i]);
	endtask

	task automatic post_draft();
		char_req_t req;
		foreach (draft[i]) begin
			req.ch   = draft[i];
			req.last = (i == draft.size() - 1);
			outbox.insert(outbox.size(), req);
		end
		items_queued += draft.size();
		texts_queued++;
	endtask

	task automatic queue_text(input string s);
		draft.delete();
		add_str(s);
		post_draft();
	endtask

	task automatic queue_nest(input int n);
		draft.delete();
		repeat (n) add_str("<Q>");
		repeat (n) add_str("</Q>");
		post_draft();
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (b == CH_LT) b = 8'hBC;
		return b;
	endfunction

	function automatic logic [7:0] tagish_byte();
		case ($urandom_range(7))
			0:       return CH_LT;
			1:       return CH_GT;
			2:       return CH_SLASH;
			3:       return CH_BANG;
			4:       return ($urandom_range(1) != 0) ? CH_LBRK : CH_RBRK;
			5, 6:    return 8'($urandom_range(CH_CAP_A, CH_CAP_Z));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic open_tag();
		int len;
		len = ($urandom_range(7) == 0) ? $urandom_range(1, NAME_MAX_LEN) : $urandom_range(1, 3);
		draft.insert(draft.size(), CH_LT);
		tag_at.insert(tag_at.size(), draft.size());
		tag_len.insert(tag_len.size(), len);
		repeat (len) draft.insert(draft.size(), 8'($urandom_range(CH_CAP_A, CH_CAP_Z)));
		draft.insert(draft.size(), CH_GT);
	endtask

	task automatic close_tag();
		int at;
		int len;
		at  = tag_at.pop_back();
		len = tag_len.pop_back();
		draft.insert(draft.size(), CH_LT);
		draft.insert(draft.size(), CH_SLASH);
		for (int i = 0; i < len; i++) draft.insert(draft.size(), draft[at + i]);
		draft.insert(draft.size(), CH_GT);
	endtask

	task automatic draft_cdata();
		add_str(($urandom_range(1) != 0) ? "<![CDATA[" : "<![cdata[");
		repeat ($urandom_range(4)) begin
			case ($urandom_range(3))
				0:       draft.insert(draft.size(), CH_RBRK);
				1:       draft.insert(draft.size(), tagish_byte());
				default: draft.insert(draft.size(), 8'($urandom_range(255)));
			endcase
		end
		add_str("]]>");
	endtask

	// Well-formed document with random content; now and then nested to the stack limit or one past it
	task automatic draft_good();
		int cap;
		int r;
		draft.delete();
		tag_at.delete();
		tag_len.delete();
		if ($urandom_range(19) == 0) begin
			cap = STACK_DEPTH + $urandom_range(1);
			repeat (cap) open_tag();
		end else begin
			cap = 4;
			open_tag();
		end
		repeat ($urandom_range(1, 8)) begin
			r = $urandom_range(99);
			if (r < 30 && tag_at.size() < cap) open_tag();
			else if (r < 55 && tag_at.size() > 1) close_tag();
			else if (r < 72) draft_cdata();
			else repeat ($urandom_range(1, 3)) draft.insert(draft.size(), text_byte());
		end
		while (tag_at.size() != 0) close_tag();
	endtask

	task automatic draft_noise();
		draft.delete();
		repeat ($urandom_range(1, 12))
			draft.insert(draft.size(),
				($urandom_range(1) != 0) ? tagish_byte() : 8'($urandom_range(255)));
	endtask

	// Break a document: overwrite, cut short, insert or append one byte
	task automatic spoil_draft();
		int pos;
		pos = $urandom_range(draft.size() - 1);
		case ($urandom_range(3))
			0:       draft[pos] = tagish_byte();
			1:       while (draft.size() > pos + 1) void'(draft.pop_back());
			2:       draft.insert(pos, tagish_byte());
			default: draft.insert(draft.size(), tagish_byte());
		endcase
	endtask

	task automatic random_texts(input int n);
		int item_goal;
		int text_goal;
		int r;
		item_goal = items_queued + n;
		text_goal = texts_queued + 2;
		while (items_queued < item_goal || texts_queued < text_goal) begin
			r = $urandom_range(99);
			if (r < 10) begin
				draft_noise();
			end else begin
				draft_good();
				if (r < 35) spoil_draft();
			end
			post_draft();
		end
	endtask

	// Hold the sender until every request is in and every verdict is out
	task automatic wait_drained();
		while (outbox.size() != 0 || in_valid || verdicts.size() != 0) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- driver
	// Hold a request until it is taken; then offer the next one, or idle
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_took)) begin
			if (outbox.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = outbox.pop_front();
				char_byte <= next_req.ch;
				last_char <= next_req.last;
				in_valid  <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the verdict side at random, or for one long stretch when asked
	always @(negedge clk) begin
		if (hold_go && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ---------------------------------------------------------------- monitor
	// Predict on each accepted request; compare each accepted verdict with the oldest one
	always @(posedge clk) begin
		if (arst_n) begin
			in_took <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				scan_char(char_byte, last_char, pred_done, pred_ok);
				if (pred_done) verdicts.insert(verdicts.size(), pred_ok);
			end
			if (out_valid && out_ready) begin
				if (verdicts.size() == 0) begin
					flag_mismatch($sformatf("verdict %b with no text pending", is_valid));
				end else begin
					exp_ok = verdicts.pop_front();
					if (is_valid !== exp_ok)
						flag_mismatch($sformatf("is_valid %b, expected %b", is_valid, exp_ok));
				end
			end
		end
	end

	// Stop when no request moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
				$display("tag_nesting_validator_tb: done, errors");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin
		checker_clear();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed texts: name lengths, CDATA forms, nesting, several ways to go wrong
		queue_text("<ABCDEFGHI></ABCDEFGHI>");
		queue_text("<ABCDEFGHIJ></ABCDEFGHIJ>");
		queue_text("<A><![CDATA[x]]]>y]]></A>");
		queue_text("<A><![cdata[<B>]]>t</A>");
		queue_text("<A><![CData[x]]></A>");
		queue_text("<A><!B></A>");
		queue_text("x<A></A>");
		queue_text("<A></A><B></B>");
		queue_text("<A></A>x");
		queue_text("<A></B>");
		queue_text("<A></></A>");
		queue_text("<A><");
		queue_text("<A");
		queue_text("<A><![CDATA[ab");
		queue_text("<A><![CD");
		queue_nest(STACK_DEPTH);
		queue_nest(STACK_DEPTH + 1);
		draft.delete();
		add_str("<A>");
		draft.insert(draft.size(), 8'h00);
		draft.insert(draft.size(), 8'hFF);
		draft.insert(draft.size(), 8'h80);
		add_str("</A>");
		post_draft();
		wait_drained();

		// No idling; the verdict side holds off long enough to back up the input
		hold_go = 1'b1;
		random_texts(20);
		wait_drained();

		send_idle_pct = 78;
		random_texts(20);
		wait_drained();

		send_idle_pct  = 0;
		recv_stall_pct = 78;
		random_texts(20);
		wait_drained();

		send_idle_pct  = 35;
		recv_stall_pct = 35;
		random_texts(20);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) $display("tag_nesting_validator_tb: done, clean");
		else $display("tag_nesting_validator_tb: done, errors");
		$finish;
	end

endmodule
